// ===== rtl/core/ltb_pkg.sv =====
// Shared types, constants and helpers for the line evicting text buffer.
// No dependencies; used by every module in rtl/core except ltb_ram.

package ltb_pkg;

  // Store geometry: ring of CAPACITY bytes
  localparam int unsigned CAPACITY = 512;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned CHAR_W   = 8;

  localparam logic [CHAR_W-1:0] NEWLINE = 8'd10;

  // Input action codes
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_RD_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_APPEND
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch the input item
    logic rd_scan;   // RAM read address from scan counter, else from read offset
    logic scan_inc;  // step scan to next character
    logic evict;     // drop scan+1 oldest characters
    logic write;     // append the latched character
    logic respond;   // load and strobe the result
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_read;
    logic full;
    logic off_valid;
    logic data_nl;
    logic scan_last;
  } sts_t;

  // Ring index of the character at offset off from base (off <= CAPACITY)
  function automatic logic [ADDR_W-1:0] ring_index(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0]  off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, base} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(CAPACITY)) begin
      sum = sum - (CNT_W + 1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

endpackage

// ===== rtl/core/ltb_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.

module ltb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ltb_datapath.sv =====
// Datapath: character store, ring pointers, scan counter and result registers.
// Depends on ltb_pkg and ltb_ram.

module ltb_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ltb_pkg::cmd_t                cmd_i,
  output ltb_pkg::sts_t                sts_o,
  input  logic                         action_i,
  input  logic [ltb_pkg::CHAR_W-1:0]   char_in_i,
  input  logic [ltb_pkg::ADDR_W-1:0]   read_offset_i,
  output logic                         result_valid_o,
  output logic [ltb_pkg::CHAR_W-1:0]   read_char_o,
  output logic [ltb_pkg::CNT_W-1:0]    text_length_o,
  output logic [ltb_pkg::CNT_W-1:0]    evicted_count_o
);

  logic [ltb_pkg::ADDR_W-1:0] oldest_q, oldest_d;
  logic [ltb_pkg::CNT_W-1:0]  count_q, count_d;
  logic [ltb_pkg::CNT_W-1:0]  scan_q, scan_d;
  logic [ltb_pkg::CNT_W-1:0]  evicted_q, evicted_d;
  logic                       valid_q;
  logic                       act_q;
  logic [ltb_pkg::CHAR_W-1:0] ch_q;
  logic [ltb_pkg::ADDR_W-1:0] off_q;
  logic [ltb_pkg::CHAR_W-1:0] rd_char_q, rd_char_d;

  logic [ltb_pkg::ADDR_W-1:0] raddr, waddr;
  logic [ltb_pkg::CHAR_W-1:0] rdata;
  logic [ltb_pkg::CNT_W-1:0]  scan_next;
  logic [ltb_pkg::CNT_W-1:0]  count_after_evict;

  // Character store
  ltb_ram #(
    .WIDTH (ltb_pkg::CHAR_W),
    .DEPTH (ltb_pkg::CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.write),
    .waddr_i (waddr),
    .wdata_i (ch_q),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Ring addressing
  assign waddr = ltb_pkg::ring_index(oldest_q, count_q);
  assign raddr = cmd_i.rd_scan
               ? ltb_pkg::ring_index(oldest_q, scan_q)
               : ltb_pkg::ring_index(oldest_q, {1'b0, off_q});

  assign scan_next         = scan_q + 1'b1;
  assign count_after_evict = count_q - scan_next;

  // Status to controller
  assign sts_o.is_read   = (act_q == ltb_pkg::ACT_READ);
  assign sts_o.full      = (count_q == ltb_pkg::CNT_W'(ltb_pkg::CAPACITY));
  assign sts_o.off_valid = ({1'b0, off_q} < count_q);
  assign sts_o.data_nl   = (rdata == ltb_pkg::NEWLINE);
  assign sts_o.scan_last = (scan_q == ltb_pkg::CNT_W'(ltb_pkg::CAPACITY - 1));

  // Next-state logic for pointers, scan and result
  always_comb begin
    oldest_d  = oldest_q;
    count_d   = count_q;
    scan_d    = scan_q;
    evicted_d = evicted_q;
    rd_char_d = rd_char_q;
    if (cmd_i.capture) begin
      scan_d    = '0;
      evicted_d = '0;
    end
    if (cmd_i.scan_inc) begin
      scan_d = scan_next;
    end
    // scan_q is the position of the newline, or the last character
    if (cmd_i.evict) begin
      evicted_d = scan_next;
      count_d   = count_after_evict;
      oldest_d  = (count_after_evict == '0) ? '0
                                            : ltb_pkg::ring_index(oldest_q, scan_next);
    end
    if (cmd_i.write) begin
      count_d = count_q + 1'b1;
    end
    if (cmd_i.respond) begin
      rd_char_d = (sts_o.is_read && sts_o.off_valid) ? rdata : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oldest_q  <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      evicted_q <= '0;
      valid_q   <= 1'b0;
    end else begin
      oldest_q  <= oldest_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      evicted_q <= evicted_d;
      valid_q   <= cmd_i.respond;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= action_i;
      ch_q  <= char_in_i;
      off_q <= read_offset_i;
    end
    rd_char_q <= rd_char_d;
  end

  assign result_valid_o  = valid_q;
  assign read_char_o     = rd_char_q;
  assign text_length_o   = count_q;
  assign evicted_count_o = evicted_q;

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= ltb_pkg::CNT_W'(ltb_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_empty_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (oldest_q == '0))
    else $error("empty store with nonzero oldest position");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> !valid_q)
    else $error("result strobe held for more than one cycle");

  a_evict_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && evicted_q != '0) |-> (rd_char_q == '0))
    else $error("evicting append returned a character");

endmodule

// ===== rtl/core/ltb_ctrl.sv =====
// Controller state machine: sequences read, append and line eviction scan.
// Depends on ltb_pkg.

module ltb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ltb_pkg::sts_t sts_i,
  output ltb_pkg::cmd_t cmd_o
);

  ltb_pkg::state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ltb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    unique case (state_q)
      ltb_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ltb_pkg::ST_CHECK;
        end
      end
      ltb_pkg::ST_CHECK: begin
        if (sts_i.is_read) begin
          // read address issued here from the offset
          if (sts_i.off_valid) begin
            state_d = ltb_pkg::ST_RD_WAIT;
          end else begin
            cmd_o.respond = 1'b1;
            state_d       = ltb_pkg::ST_IDLE;
          end
        end else if (sts_i.full) begin
          state_d = ltb_pkg::ST_SCAN_RD;
        end else begin
          cmd_o.write   = 1'b1;
          cmd_o.respond = 1'b1;
          state_d       = ltb_pkg::ST_IDLE;
        end
      end
      ltb_pkg::ST_RD_WAIT: begin
        cmd_o.respond = 1'b1;
        state_d       = ltb_pkg::ST_IDLE;
      end
      ltb_pkg::ST_SCAN_RD: begin
        cmd_o.rd_scan = 1'b1;
        state_d       = ltb_pkg::ST_SCAN_CMP;
      end
      ltb_pkg::ST_SCAN_CMP: begin
        // stop at the first newline, or drop all when none is found
        if (sts_i.data_nl || sts_i.scan_last) begin
          cmd_o.evict = 1'b1;
          state_d     = ltb_pkg::ST_APPEND;
        end else begin
          cmd_o.scan_inc = 1'b1;
          state_d        = ltb_pkg::ST_SCAN_RD;
        end
      end
      ltb_pkg::ST_APPEND: begin
        cmd_o.write   = 1'b1;
        cmd_o.respond = 1'b1;
        state_d       = ltb_pkg::ST_IDLE;
      end
      default: begin
        state_d = ltb_pkg::ST_IDLE;
      end
    endcase
  end

  // Checks
  a_cmp_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ltb_pkg::ST_SCAN_CMP) |-> ($past(state_q) == ltb_pkg::ST_SCAN_RD))
    else $error("scan compare without a preceding scan read");

  a_write_not_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.write |-> !sts_i.is_read)
    else $error("store written during a read item");

  a_evict_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.evict |-> sts_i.full)
    else $error("eviction on a store that is not full");

endmodule

// ===== rtl/core/line_evicting_text_buffer_top.sv =====
// Line evicting text buffer: a scrollback store of 512 characters in a ring.
// An item is taken when start is high and busy is low. A read inside the
// stored text passes the check and RAM read wait states before its result;
// a read beyond the length or a plain append responds from the check state.
// An append to a full store first scans from the oldest character to the
// first newline, one RAM read and one compare per character scanned, then
// drops up to and including the newline (all when none is stored) and appends.
// Each result is on the result ports in the cycle that result_valid_o is
// high, a one-cycle strobe; the receiver cannot stall it, and the next item
// may be started in that same cycle.
// Depends on ltb_pkg, ltb_ctrl, ltb_datapath and ltb_ram.

module line_evicting_text_buffer_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       action_i,
  input  logic [ltb_pkg::CHAR_W-1:0] char_in_i,
  input  logic [ltb_pkg::ADDR_W-1:0] read_offset_i,
  output logic                       result_valid_o,
  output logic [ltb_pkg::CHAR_W-1:0] read_char_o,
  output logic [ltb_pkg::CNT_W-1:0]  text_length_o,
  output logic [ltb_pkg::CNT_W-1:0]  evicted_count_o
);

  ltb_pkg::cmd_t cmd;
  ltb_pkg::sts_t sts;

  // Sequencer
  ltb_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  // Store and arithmetic
  ltb_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .char_in_i       (char_in_i),
    .read_offset_i   (read_offset_i),
    .result_valid_o  (result_valid_o),
    .read_char_o     (read_char_o),
    .text_length_o   (text_length_o),
    .evicted_count_o (evicted_count_o)
  );

endmodule
